// ===== hw/rtl/nq_pkg.sv =====
`default_nettype none

package nq_pkg;

  // Row and column counters hold 0..16: the result fields cap a board at 16.
  localparam int unsigned CntW        = 5;
  localparam int unsigned FieldW      = 4;
  localparam int unsigned ResultLimit = 16;
  localparam int unsigned MaxNDefault = 16;

  typedef enum logic [1:0] {
    MASK_NOP,
    MASK_CLEAR,
    MASK_MARK,
    MASK_UNMARK
  } mask_op_e;

  typedef struct packed {
    mask_op_e        op;
    logic [CntW-1:0] n;
    logic [CntW-1:0] row;
    logic [CntW-1:0] col;
  } mask_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRY,
    ST_POP,
    ST_UNDO,
    ST_READ,
    ST_OUT,
    ST_FAIL
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/n_queens_first_solution.sv =====
`default_nettype none

// N-queens first-solution search. One input beat carries a board size n; the
// block runs a depth-first backtracking search, one column test per cycle outside
// backtracks, on a shared occupancy unit. A backtrack finds the row exhausted,
// then pops the column stack through ST_POP and ST_UNDO. The first solution
// comes out as n beats in row order, each read from the stack in ST_READ and
// shown in ST_OUT, last_of_run set on the final row. Boards of 2 or 3, 0, or
// above min(MAX_N, 16) give one beat with found = 0. No new beat is taken until
// the last result beat has gone out.

module n_queens_first_solution
  import nq_pkg::*;
#(
  parameter int unsigned MAX_N = MaxNDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CntW-1:0]   board_size_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FieldW-1:0] row_index_o,
  output logic [FieldW-1:0] queen_column_o,
  output logic              found_o,
  output logic              last_of_run_o
);

  localparam int unsigned Lim   = (MAX_N < ResultLimit) ? MAX_N : ResultLimit;
  localparam int unsigned AddrW = $clog2(Lim);

  state_e            state_q, state_d;
  logic [CntW-1:0]   n_q, n_d;
  logic [CntW-1:0]   row_q, row_d;
  logic [CntW-1:0]   col_q, col_d;
  logic [CntW-1:0]   orow_q, orow_d;
  logic [CntW-1:0]   row_m1;
  mask_cmd_t         mask_cmd;
  logic              free;
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [FieldW-1:0] ram_rdata;
  logic              in_fire, out_fire, bad_size, out_last;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign bad_size = (board_size_i == '0) || (board_size_i > CntW'(Lim));
  assign row_m1   = row_q - CntW'(1);
  assign out_last = (orow_q == n_q - CntW'(1));

  nq_mask #(
    .Lim(Lim)
  ) u_mask (
    .clk_i,
    .rst_ni,
    .cmd_i (mask_cmd),
    .free_o(free)
  );

  nq_ram #(
    .Width(FieldW),
    .Depth(Lim)
  ) u_stack (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(row_q[AddrW-1:0]),
    .wdata_i(col_q[FieldW-1:0]),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = bad_size ? ST_FAIL : ST_TRY;
      end
      ST_TRY: begin
        if (row_q == n_q)          state_d = ST_READ;
        else if (col_q < n_q)      state_d = ST_TRY;
        else if (row_q == '0)      state_d = ST_FAIL;
        else                       state_d = ST_POP;
      end
      ST_POP:  state_d = ST_UNDO;
      ST_UNDO: state_d = ST_TRY;
      ST_READ: state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) state_d = out_last ? ST_IDLE : ST_READ;
      end
      ST_FAIL: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    row_index_o    = '0;
    queen_column_o = '0;
    found_o        = 1'b0;
    last_of_run_o  = 1'b0;
    mask_cmd.op    = MASK_NOP;
    mask_cmd.n     = n_q;
    mask_cmd.row   = row_q;
    mask_cmd.col   = col_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = orow_q[AddrW-1:0];
    n_d            = n_q;
    row_d          = row_q;
    col_d          = col_q;
    orow_d         = orow_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          mask_cmd.op = MASK_CLEAR;
          n_d         = board_size_i;
          row_d       = '0;
          col_d       = '0;
        end
      end
      ST_TRY: begin
        if (row_q == n_q) begin
          orow_d = '0;
        end else if (col_q < n_q) begin
          if (free) begin
            mask_cmd.op = MASK_MARK;
            ram_we      = 1'b1;
            row_d       = row_q + CntW'(1);
            col_d       = '0;
          end else begin
            col_d = col_q + CntW'(1);
          end
        end else if (row_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = row_m1[AddrW-1:0];
          row_d     = row_m1;
        end
      end
      ST_UNDO: begin
        // lift the queen of this row and resume one column to the right
        mask_cmd.op  = MASK_UNMARK;
        mask_cmd.col = CntW'(ram_rdata);
        col_d        = CntW'(ram_rdata) + CntW'(1);
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_OUT: begin
        out_valid_o    = 1'b1;
        row_index_o    = orow_q[FieldW-1:0];
        queen_column_o = ram_rdata;
        found_o        = 1'b1;
        last_of_run_o  = out_last;
        if (out_ready_i) orow_d = orow_q + CntW'(1);
      end
      ST_FAIL: begin
        out_valid_o   = 1'b1;
        last_of_run_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
      row_q   <= '0;
      col_q   <= '0;
      orow_q  <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      row_q   <= row_d;
      col_q   <= col_d;
      orow_q  <= orow_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result beat is pending");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRY) |-> (row_q <= n_q))
    else $error("search depth beyond board size");

  a_fail_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> last_of_run_o)
    else $error("failure beat without last flag");

  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_of_run_o) |=> in_ready_o)
    else $error("not ready after final result beat");

endmodule

`default_nettype wire

// ===== hw/rtl/nq_ram.sv =====
`default_nettype none

module nq_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nq_mask.sv =====
`default_nettype none

module nq_mask
  import nq_pkg::*;
#(
  parameter int unsigned Lim = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mask_cmd_t cmd_i,
  output logic      free_o
);

  localparam int unsigned DiagW    = 2 * Lim - 1;
  localparam int unsigned ColIdxW  = $clog2(Lim);
  localparam int unsigned DiagIdxW = $clog2(DiagW);

  logic [Lim-1:0]      cols_q, cols_d;
  logic [DiagW-1:0]    down_q, down_d;
  logic [DiagW-1:0]    up_q, up_d;
  logic [ColIdxW-1:0]  col_idx;
  logic [CntW:0]       down_sum, up_sum;
  logic [DiagIdxW-1:0] down_idx, up_idx;
  logic [Lim-1:0]      col_bit;
  logic [DiagW-1:0]    down_bit, up_bit;

  // down diagonal: row - col + n - 1, up diagonal: row + col
  assign down_sum = {1'b0, cmd_i.row} + {1'b0, cmd_i.n} - (CntW+1)'(1) - {1'b0, cmd_i.col};
  assign up_sum   = {1'b0, cmd_i.row} + {1'b0, cmd_i.col};
  assign col_idx  = cmd_i.col[ColIdxW-1:0];
  assign down_idx = down_sum[DiagIdxW-1:0];
  assign up_idx   = up_sum[DiagIdxW-1:0];

  assign col_bit  = Lim'(1) << col_idx;
  assign down_bit = DiagW'(1) << down_idx;
  assign up_bit   = DiagW'(1) << up_idx;

  assign free_o = !(|(cols_q & col_bit)) && !(|(down_q & down_bit)) && !(|(up_q & up_bit));

  always_comb begin
    cols_d = cols_q;
    down_d = down_q;
    up_d   = up_q;
    case (cmd_i.op)
      MASK_CLEAR: begin
        cols_d = '0;
        down_d = '0;
        up_d   = '0;
      end
      MASK_MARK: begin
        cols_d = cols_q | col_bit;
        down_d = down_q | down_bit;
        up_d   = up_q | up_bit;
      end
      MASK_UNMARK: begin
        cols_d = cols_q & ~col_bit;
        down_d = down_q & ~down_bit;
        up_d   = up_q & ~up_bit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= '0;
      down_q <= '0;
      up_q   <= '0;
    end else begin
      cols_q <= cols_d;
      down_q <= down_d;
      up_q   <= up_d;
    end
  end

endmodule

`default_nettype wire

// ===== test/n_queens_first_solution_tb.sv =====
module n_queens_first_solution_tb;
  import nq_pkg::*;

  typedef struct packed {
    logic [FieldW-1:0] row_idx;
    logic [FieldW-1:0] column;
    logic              found;
    logic              last;
  } queen_beat_t;

  typedef struct packed {
    logic [CntW-1:0] size;
    logic            typed;
    queen_beat_t     beat;
  } board_row_t;

  localparam queen_beat_t FailBeat = '{4'd0, 4'd0, 1'b0, 1'b1};
  localparam queen_beat_t SoloBeat = '{4'd0, 4'd0, 1'b1, 1'b1};
  localparam queen_beat_t NoBeat   = '{4'd0, 4'd0, 1'b0, 1'b0};
  localparam int unsigned NumBoards = 20;

  logic              clk;
  logic              rst_n;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CntW-1:0]   board_size = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [FieldW-1:0] row_index;
  logic [FieldW-1:0] queen_column;
  logic              found;
  logic              last_of_run;

  // typed rows carry their result in the table, the rest go through the search
  board_row_t board_rows [NumBoards] = '{
    '{5'd1,  1'b1, SoloBeat}, '{5'd0,  1'b1, FailBeat}, '{5'd2,  1'b1, FailBeat},
    '{5'd3,  1'b1, FailBeat}, '{5'd4,  1'b0, NoBeat},   '{5'd5,  1'b0, NoBeat},
    '{5'd6,  1'b0, NoBeat},   '{5'd7,  1'b0, NoBeat},   '{5'd8,  1'b0, NoBeat},
    '{5'd9,  1'b0, NoBeat},   '{5'd10, 1'b0, NoBeat},   '{5'd11, 1'b0, NoBeat},
    '{5'd12, 1'b0, NoBeat},   '{5'd13, 1'b0, NoBeat},   '{5'd14, 1'b0, NoBeat},
    '{5'd15, 1'b0, NoBeat},   '{5'd16, 1'b0, NoBeat},   '{5'd17, 1'b1, FailBeat},
    '{5'd24, 1'b1, FailBeat}, '{5'd31, 1'b1, FailBeat}
  };

  queen_beat_t pending_rows [$];
  int unsigned errors = 0;
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 54;
  bit          row_typed = 1'b0;
  queen_beat_t row_beat = NoBeat;

  n_queens_first_solution dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .board_size_i   (board_size),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .row_index_o    (row_index),
    .queen_column_o (queen_column),
    .found_o        (found),
    .last_of_run_o  (last_of_run)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Depth-first search, one queen per row, columns tried low to high.
  function automatic bit place_queens(input int unsigned n, output logic [3:0] cols [16]);
    logic [15:0] col_busy;
    logic [31:0] down_busy;
    logic [31:0] up_busy;
    int unsigned row;
    int unsigned start;
    int unsigned c;
    bit          placed;
    col_busy  = '0;
    down_busy = '0;
    up_busy   = '0;
    row       = 0;
    start     = 0;
    foreach (cols[i]) cols[i] = '0;
    if (n == 0 || n > 16) return 1'b0;
    while (row < n) begin
      placed = 1'b0;
      for (c = start; c < n && !placed; c++) begin
        if (!col_busy[c] && !down_busy[row + n - 1 - c] && !up_busy[row + c]) begin
          col_busy[c]              = 1'b1;
          down_busy[row + n - 1 - c] = 1'b1;
          up_busy[row + c]         = 1'b1;
          cols[row]                = c[3:0];
          row++;
          start  = 0;
          placed = 1'b1;
        end
      end
      if (!placed) begin
        if (row == 0) return 1'b0;
        row--;
        c                        = 32'(cols[row]);
        col_busy[c]              = 1'b0;
        down_busy[row + n - 1 - c] = 1'b0;
        up_busy[row + c]         = 1'b0;
        start                    = c + 1;
      end
    end
    return 1'b1;
  endfunction

  task automatic queue_solution(input logic [CntW-1:0] size);
    logic [3:0]  cols [16];
    queen_beat_t b;
    int unsigned n_rows;
    n_rows = 32'(size);
    if (!place_queens(n_rows, cols)) begin
      pending_rows.push_back(FailBeat);
    end else begin
      for (int unsigned r = 0; r < n_rows; r++) begin
        b.row_idx = r[3:0];
        b.column  = cols[r];
        b.found   = 1'b1;
        b.last    = (r + 1 == n_rows);
        pending_rows.push_back(b);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    queen_beat_t head;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (row_typed) pending_rows.push_back(row_beat);
        else queue_solution(board_size);
      end
      if (out_valid && out_ready) begin
        if (pending_rows.size() == 0) begin
          report_mismatch($sformatf("unexpected beat row %0d col %0d found %b last %b",
                                    row_index, queen_column, found, last_of_run));
        end else begin
          head = pending_rows.pop_front();
          if (row_index !== head.row_idx)
            report_mismatch($sformatf("row_index %0d, want %0d", row_index, head.row_idx));
          if (queen_column !== head.column)
            report_mismatch($sformatf("queen_column %0d, want %0d (row %0d)",
                                      queen_column, head.column, head.row_idx));
          if (found !== head.found)
            report_mismatch($sformatf("found %b, want %b (row %0d)",
                                      found, head.found, head.row_idx));
          if (last_of_run !== head.last)
            report_mismatch($sformatf("last_of_run %b, want %b (row %0d)",
                                      last_of_run, head.last, head.row_idx));
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_board(input logic [CntW-1:0] size, input bit typed,
                            input queen_beat_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    row_typed = typed;
    row_beat  = beat;
    in_valid   <= 1'b1;
    board_size <= size;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  // mostly small boards; 11..13 still resolve quickly, 14..16 are directed only, 17..31 fail at once
  function automatic logic [CntW-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return CntW'($urandom_range(4, 10));
    if (r < 60) return CntW'($urandom_range(0, 3));
    if (r < 92) return CntW'($urandom_range(17, 31));
    return CntW'($urandom_range(11, 13));
  endfunction

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (board_rows[i]) send_board(board_rows[i].size, board_rows[i].typed, board_rows[i].beat);
    hold_until_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 36 : 0;
      for (int k = 0; k < 34; k++) send_board(pick_size(), 1'b0, NoBeat);
      hold_until_drained();
    end

    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("[n_queens_first_solution] OK");
    end else begin
      $display("[n_queens_first_solution] ERROR");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("timeout, %0d beats still expected", pending_rows.size());
    $display("[n_queens_first_solution] ERROR");
    $finish;
  end

endmodule
